// ===== rtl/core/pwbd_pkg.sv =====
package pwbd_pkg;

  // Timestamps and pulse widths are taken modulo 2^TimeWidth.
  localparam int TimeWidth   = 32;
  localparam int BufferDepth = 256;
  localparam int CountWidth  = $clog2(BufferDepth + 1);
  localparam int CalPulses   = 8;
  localparam int CalWidth    = $clog2(CalPulses + 1);
  // Eight calibration widths need three extra bits; the threshold is the sum over eight.
  localparam int SumWidth    = TimeWidth + 3;
  localparam int ByteWidth   = 8;
  localparam int BitPosWidth = $clog2(ByteWidth);

  typedef enum logic [1:0] {
    CMD_RISE    = 2'd0,
    CMD_FALL    = 2'd1,
    CMD_RESTART = 2'd2,
    CMD_UNUSED  = 2'd3
  } cmd_e;

endpackage

// ===== rtl/core/pulse_width_bit_decoder.sv =====
// A result item is shown in the cycle after its input item is accepted.
// Throughput: one item per cycle unless the output stalls; all decoder state
// updates on accept, and one output register holds the result while stalled.
// Reset (rst_ni low, asynchronous) clears the calibration, the byte assembly,
// the byte count and the overflow flag, and empties the output register.
module pulse_width_bit_decoder
  import pwbd_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  logic [1:0]            command_i,
  input  logic [31:0]           time_us_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic                  byte_ready_o,
  output logic [7:0]            byte_value_o,
  output logic [7:0]            byte_index_o,
  output logic                  calibrated_o,
  output logic [31:0]           threshold_o,
  output logic [CountWidth-1:0] length_o,
  output logic                  overflow_o
);

  logic [TimeWidth-1:0]   rise_q, rise_d;
  logic [SumWidth-1:0]    total_q, total_d;
  logic [CalWidth-1:0]    cal_q, cal_d;
  logic [TimeWidth-1:0]   level_q, level_d;
  logic [BitPosWidth-1:0] pos_q, pos_d;
  logic [ByteWidth-1:0]   partial_q, partial_d;
  logic [CountWidth-1:0]  count_q, count_d;
  logic                   ovf_q, ovf_d;
  logic                   out_valid_q;

  logic                   accept;
  logic [TimeWidth-1:0]   width;
  logic [SumWidth-1:0]    total_next;
  logic                   data_bit;
  logic [ByteWidth-1:0]   completed;
  logic                   res_ready;
  logic [ByteWidth-1:0]   res_value;
  logic [ByteWidth-1:0]   res_index;

  assign in_ready_o = !out_valid_q || out_ready_i;
  assign accept     = in_valid_i && in_ready_o;

  assign width      = time_us_i - rise_q;
  assign total_next = total_q + SumWidth'(width);
  assign data_bit   = width > level_q;
  assign completed  = partial_q | (ByteWidth'(data_bit) << pos_q);

  always_comb begin
    rise_d    = rise_q;
    total_d   = total_q;
    cal_d     = cal_q;
    level_d   = level_q;
    pos_d     = pos_q;
    partial_d = partial_q;
    count_d   = count_q;
    ovf_d     = ovf_q;
    res_ready = 1'b0;
    res_value = '0;
    res_index = '0;
    unique case (cmd_e'(command_i))
      CMD_RISE: begin
        rise_d = time_us_i;
      end
      CMD_FALL: begin
        if (cal_q != CalWidth'(CalPulses)) begin
          total_d = total_next;
          cal_d   = cal_q + 1'b1;
          if (cal_q == CalWidth'(CalPulses - 1)) begin
            level_d = total_next[SumWidth-1:3];
          end
        end else begin
          pos_d     = pos_q + 1'b1;
          partial_d = completed;
          if (pos_q == BitPosWidth'(ByteWidth - 1)) begin
            partial_d = '0;
            // A full buffer drops the byte but still restarts bit assembly.
            if (count_q == CountWidth'(BufferDepth)) begin
              ovf_d = 1'b1;
            end else begin
              res_ready = 1'b1;
              res_value = completed;
              res_index = count_q[ByteWidth-1:0];
              count_d   = count_q + 1'b1;
            end
          end
        end
      end
      CMD_RESTART: begin
        rise_d    = '0;
        total_d   = '0;
        cal_d     = '0;
        level_d   = '0;
        pos_d     = '0;
        partial_d = '0;
        count_d   = '0;
        ovf_d     = 1'b0;
      end
      CMD_UNUSED: begin
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rise_q      <= '0;
      total_q     <= '0;
      cal_q       <= '0;
      level_q     <= '0;
      pos_q       <= '0;
      partial_q   <= '0;
      count_q     <= '0;
      ovf_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (accept) begin
        rise_q    <= rise_d;
        total_q   <= total_d;
        cal_q     <= cal_d;
        level_q   <= level_d;
        pos_q     <= pos_d;
        partial_q <= partial_d;
        count_q   <= count_d;
        ovf_q     <= ovf_d;
      end
      if (in_ready_o) begin
        out_valid_q <= in_valid_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      byte_ready_o <= res_ready;
      byte_value_o <= res_value;
      byte_index_o <= res_index;
      calibrated_o <= (cal_d == CalWidth'(CalPulses));
      threshold_o  <= 32'(level_d);
      length_o     <= count_d;
      overflow_o   <= ovf_d;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

// ===== rtl/core/pwbd_checker.sv =====
module pwbd_checker
  import pwbd_pkg::*;
(
  input logic                  clk_i,
  input logic                  rst_ni,
  input logic                  in_valid_i,
  input logic                  in_ready_o,
  input logic [1:0]            command_i,
  input logic                  out_valid_o,
  input logic                  out_ready_i,
  input logic                  byte_ready_o,
  input logic [7:0]            byte_value_o,
  input logic [7:0]            byte_index_o,
  input logic                  calibrated_o,
  input logic [31:0]           threshold_o,
  input logic [CountWidth-1:0] length_o,
  input logic                  overflow_o
);

  // A stalled result item keeps its whole payload.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(byte_value_o)
      && $stable(length_o) && $stable(threshold_o) && $stable(byte_ready_o)
      && $stable(byte_index_o) && $stable(calibrated_o) && $stable(overflow_o))
    else $error("stalled result item changed");

  // Bytes are only decoded after calibration.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && byte_ready_o |-> calibrated_o)
    else $error("byte reported before calibration");

  // The reported length already counts the byte that is delivered with it.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && byte_ready_o |-> byte_index_o == (length_o[7:0] - 8'd1))
    else $error("byte index does not match length");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !calibrated_o |-> threshold_o == 32'd0)
    else $error("threshold nonzero before calibration");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && command_i == CMD_RESTART |=>
      out_valid_o && length_o == '0 && !overflow_o && !calibrated_o)
    else $error("restart did not clear decoder status");

endmodule

bind pulse_width_bit_decoder pwbd_checker u_pwbd_checker (.*);
